>>> rtl/iwdg_pkg.sv
// Shared types, key codes and prescaler decode for the independent watchdog.
package iwdg_pkg;

  localparam int COUNT_W   = 12;
  localparam int DATA_W    = 16;
  localparam int DIV_W     = 8;
  localparam int CODE_W    = 3;
  localparam int COUNT_MAX = 4095;

  localparam logic [DATA_W-1:0] KEY_UNLOCK = 16'h5555;
  localparam logic [DATA_W-1:0] KEY_RELOAD = 16'hAAAA;
  localparam logic [DATA_W-1:0] KEY_START  = 16'hCCCC;

  localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(COUNT_MAX);

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_KEY      = 2'd1,
    MODE_PRESCALE = 2'd2,
    MODE_RELOAD   = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t              mode;
    logic [DATA_W-1:0]  write_data;
  } item_t;

  typedef struct packed {
    logic               timeout_pulse;
    logic [COUNT_W-1:0] count_now;
    logic               running;
    logic               unlocked;
  } result_t;

  // Prescaler divisor: 4 << code, saturating at 256 for the top two codes.
  function automatic logic [DIV_W:0] divisor_of(input logic [CODE_W-1:0] code);
    logic [DIV_W:0] d;
    d = '0;
    if (code >= 3'd6) begin
      d = 9'd256;
    end else begin
      d = 9'd4 << code;
    end
    return d;
  endfunction

endpackage

>>> rtl/iwdg_core.sv
// Watchdog state registers and single-pass update for one transaction.
module iwdg_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  iwdg_pkg::item_t   item,
  output iwdg_pkg::result_t res
);
  import iwdg_pkg::*;

  logic               run_flag_r, run_flag_nxt;
  logic               unlock_flag_r, unlock_flag_nxt;
  logic [CODE_W-1:0]  divider_code_r, divider_code_nxt;
  logic [COUNT_W-1:0] reload_value_r, reload_value_nxt;
  logic [COUNT_W-1:0] down_counter_r, down_counter_nxt;
  logic [DIV_W-1:0]   tick_divider_r, tick_divider_nxt;
  logic [DIV_W:0]     tick_sum;
  logic               pulse;

  assign tick_sum = {1'b0, tick_divider_r} + {{DIV_W{1'b0}}, 1'b1};

  always_comb begin
    run_flag_nxt     = run_flag_r;
    unlock_flag_nxt  = unlock_flag_r;
    divider_code_nxt = divider_code_r;
    reload_value_nxt = reload_value_r;
    down_counter_nxt = down_counter_r;
    tick_divider_nxt = tick_divider_r;
    pulse            = 1'b0;
    unique case (item.mode)
      MODE_TICK: begin
        if (run_flag_r) begin
          if (tick_sum >= divisor_of(divider_code_r)) begin
            tick_divider_nxt = '0;
            if (down_counter_r <= COUNT_W'(1)) begin
              pulse            = 1'b1;
              down_counter_nxt = reload_value_r;
            end else begin
              down_counter_nxt = down_counter_r - COUNT_W'(1);
            end
          end else begin
            tick_divider_nxt = tick_sum[DIV_W-1:0];
          end
        end
      end
      MODE_KEY: begin
        // any key other than unlock relocks the registers
        unlock_flag_nxt = (item.write_data == KEY_UNLOCK);
        if (item.write_data == KEY_START) begin
          run_flag_nxt = 1'b1;
        end
        if (item.write_data == KEY_RELOAD) begin
          down_counter_nxt = reload_value_r;
        end
      end
      MODE_PRESCALE: begin
        if (unlock_flag_r) begin
          divider_code_nxt = item.write_data[CODE_W-1:0];
        end
      end
      MODE_RELOAD: begin
        if (unlock_flag_r) begin
          reload_value_nxt = item.write_data[COUNT_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_flag_r     <= 1'b0;
      unlock_flag_r  <= 1'b0;
      divider_code_r <= '0;
      reload_value_r <= COUNT_RESET;
      down_counter_r <= COUNT_RESET;
      tick_divider_r <= '0;
    end else if (step) begin
      run_flag_r     <= run_flag_nxt;
      unlock_flag_r  <= unlock_flag_nxt;
      divider_code_r <= divider_code_nxt;
      reload_value_r <= reload_value_nxt;
      down_counter_r <= down_counter_nxt;
      tick_divider_r <= tick_divider_nxt;
    end
  end

  assign res.timeout_pulse = pulse;
  assign res.count_now     = down_counter_nxt;
  assign res.running       = run_flag_nxt;
  assign res.unlocked      = unlock_flag_nxt;

  // once started the watchdog cannot be stopped short of reset
  a_run_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> !$fell(run_flag_r))
    else $error("watchdog stopped without reset");

  // expiry reloads the counter from the reload register
  a_expiry_reload: assert property (@(posedge clk) disable iff (!rst_n)
    step && pulse |=> down_counter_r == $past(reload_value_r))
    else $error("counter not reloaded on expiry");

  // ticks while stopped leave counter and prescaler alone
  a_stopped_tick: assert property (@(posedge clk) disable iff (!rst_n)
    step && item.mode == MODE_TICK && !run_flag_r
      |=> $stable(down_counter_r) && $stable(tick_divider_r))
    else $error("stopped watchdog advanced");

  // locked register writes are dropped
  a_locked_write: assert property (@(posedge clk) disable iff (!rst_n)
    step && !unlock_flag_r && (item.mode == MODE_PRESCALE || item.mode == MODE_RELOAD)
      |=> $stable(divider_code_r) && $stable(reload_value_r))
    else $error("locked register was written");

endmodule

>>> rtl/independent_watchdog_timer.sv
// Independent watchdog timer with key register: input stage, core, result stage.
// An accepted transaction passes input stage, core and result stage to out_*.
// Throughput: one transaction per cycle when out_stall is low; the single-pass
//   update in the core (prescaler compare plus counter decrement) sets that rate.
// Reset (rst_n low, synchronous): watchdog stopped and locked, prescaler code 0,
//   reload value and down counter at 4095, both stages empty.
module independent_watchdog_timer (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_mode,
  input  logic [iwdg_pkg::DATA_W-1:0]   in_write_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_timeout_pulse,
  output logic [iwdg_pkg::COUNT_W-1:0]  out_count_now,
  output logic                          out_running,
  output logic                          out_unlocked
);
  import iwdg_pkg::*;

  // input stage
  logic    in_valid_r;
  item_t   item_r;
  // result stage
  logic    out_valid_r;
  result_t result_r;
  result_t core_res;
  logic    advance;
  logic    in_take;

  // the core step happens when the result stage is free or draining
  assign advance  = in_valid_r && (!out_valid_r || !out_stall);
  // input stage refills whenever it empties or hands its transaction on
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.mode       <= mode_t'(in_mode);
      item_r.write_data <= in_write_data;
    end
  end

  iwdg_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item_r),
    .res   (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_r <= core_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_timeout_pulse = result_r.timeout_pulse;
  assign out_count_now     = result_r.count_now;
  assign out_running       = result_r.running;
  assign out_unlocked      = result_r.unlocked;

endmodule
